@@ src/rfo_pkg.sv @@
// Shared constants, types and codes of the ring FIFO with overwrite.
package rfo_pkg;

  localparam int DEPTH     = 16;
  localparam int ELEM_BITS = 32;
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ELEM_BITS-1:0] elem_t;

  // Operation codes; the fourth code does nothing.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

endpackage

@@ src/rfo_req_if.sv @@
// Request channel of the ring FIFO: one operation and its write data.
interface rfo_req_if
  import rfo_pkg::*;
;
  logic  valid;
  logic  ready;
  logic  [1:0] operation;
  elem_t write_data;

  modport source (output valid, output operation, output write_data, input ready);
  modport sink   (input valid, input operation, input write_data, output ready);
endinterface

@@ src/rfo_rsp_if.sv @@
// Result channel of the ring FIFO: status, read data and fill levels.
interface rfo_rsp_if
  import rfo_pkg::*;
;
  logic    valid;
  logic    ready;
  status_t status;
  elem_t   read_data;
  cnt_t    fill_count;
  cnt_t    free_space;
  logic    is_empty;

  modport source (output valid, output status, output read_data, output fill_count,
                  output free_space, output is_empty, input ready);
  modport sink   (input valid, input status, input read_data, input fill_count,
                  input free_space, input is_empty, output ready);
endinterface

@@ src/ring_fifo_with_overwrite_unit.sv @@
// Top level of the ring FIFO with overwrite: pointers, count, element memory, result register.
//
// This block is a circular FIFO of DEPTH elements that takes one request at a time: write an
// element, read the oldest element, or clear all contents; any other operation code does
// nothing. Each request gives exactly one result with a status, the read data (zero unless a
// read succeeded), and the fill count, free space and empty flag after the request. A write to
// a full FIFO drops the oldest element when allow_overwrite is set (status overflow) and is
// refused otherwise (status full); a read of an empty FIFO reports status empty. A request
// is accepted, which updates the pointers and count and starts the element memory access;
// its result is then formed from the registered read data of the element memory once the
// output register is free. A new request is taken only after the last result has moved into
// the output register, where it waits; the next request is taken even while that result has
// not yet been taken. The element memory needs no clearing after reset: a read only ever
// reaches entries written before. The user must write the allow_overwrite register through
// cfg_we and cfg_wdata while the block is idle; the block does not enforce this.
module ring_fifo_with_overwrite_unit
  import rfo_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  rfo_req_if.sink   req,
  rfo_rsp_if.source rsp
);

  // Element memory, one write and one registered read per cycle.
  elem_t mem [DEPTH];
  elem_t mem_q;

  // FIFO state.
  ptr_t rd_ptr, rd_ptr_next;
  ptr_t wr_ptr, wr_ptr_next;
  cnt_t count, count_next;
  logic allow_overwrite;

  // Request waiting for its memory read data.
  logic    pend_valid;
  logic    pend_read;
  status_t pend_status;
  cnt_t    pend_count;

  // Result register.
  logic    rsp_valid;
  status_t rsp_status;
  elem_t   rsp_data;
  cnt_t    rsp_count;

  logic    req_acc;
  logic    mem_we;
  logic    mem_re;
  logic    out_load;
  status_t status_next;
  logic    full;
  logic    empty;

  function automatic ptr_t next_slot(input ptr_t p);
    next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign req.ready = !pend_valid;
  assign req_acc   = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign out_load  = pend_valid && (!rsp_valid || rsp.ready);

  // Pointer and count update for the accepted request.
  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    status_next = ST_OK;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    case (req.operation)
      OP_WRITE: begin
        if (full && !allow_overwrite) begin
          status_next = ST_FULL;
        end else begin
          mem_we      = 1'b1;
          wr_ptr_next = next_slot(wr_ptr);
          if (full) begin
            // The oldest element is dropped; the count stays at DEPTH.
            status_next = ST_OVERFLOW;
            rd_ptr_next = next_slot(rd_ptr);
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      OP_READ: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          mem_re      = 1'b1;
          rd_ptr_next = next_slot(rd_ptr);
          count_next  = count - 1'b1;
        end
      end
      OP_CLEAR: begin
        rd_ptr_next = wr_ptr;
        count_next  = '0;
      end
      default: begin
      end
    endcase
  end

  // Element memory. Write and read of one request never meet in the same cycle.
  always_ff @(posedge clk) begin
    if (req_acc && mem_we) begin
      mem[wr_ptr] <= req.write_data;
    end
    if (req_acc && mem_re) begin
      mem_q <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr          <= '0;
      wr_ptr          <= '0;
      count           <= '0;
      allow_overwrite <= 1'b0;
      pend_valid      <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        allow_overwrite <= cfg_wdata;
      end
      if (req_acc) begin
        rd_ptr     <= rd_ptr_next;
        wr_ptr     <= wr_ptr_next;
        count      <= count_next;
        pend_valid <= 1'b1;
      end else if (out_load) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_acc) begin
      pend_read   <= mem_re;
      pend_status <= status_next;
      pend_count  <= count_next;
    end
    if (out_load) begin
      rsp_status <= pend_status;
      rsp_data   <= pend_read ? mem_q : '0;
      rsp_count  <= pend_count;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.read_data  = rsp_data;
  assign rsp.fill_count = rsp_count;
  assign rsp.free_space = CNT_W'(DEPTH) - rsp_count;
  assign rsp.is_empty   = (rsp_count == '0);

  // The count never goes beyond the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // A refused write leaves the pointers and count alone.
  a_refused_write: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.operation == OP_WRITE && full && !allow_overwrite)
    |=> ($stable(count) && $stable(wr_ptr) && $stable(rd_ptr)))
    else $error("refused write changed FIFO state");

  // An accepted request always waits for its result stage next cycle.
  a_pend_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> pend_valid)
    else $error("accepted request lost");

  // A result held back by the sink keeps its payload.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_count)
                                   && $stable(rsp_data)))
    else $error("stalled result changed");

  // A successful read always brings a count below depth into its result.
  a_read_count: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.operation == OP_READ && !empty) |=> (pend_count < CNT_W'(DEPTH)))
    else $error("read result count out of range");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the ring FIFO with overwrite: directed and random requests.
module tb_top;
  import rfo_pkg::*;

  // The fourth operation code has no member in op_t; the block treats it as a no-op.
  localparam logic [1:0] OP_NOP = 2'd3;

  // Cycles to let pass once every result has come, before a register write or the end.
  localparam int DRAIN_CYCLES = 6;

  // The limit is taken many times over the length of the slowest correct run, which has
  // full idling on both sides.
  localparam int LIMIT_CYCLES = 200000;

  // One result of the block, in the field order of the result channel.
  typedef struct packed {
    status_t status;
    elem_t   read_data;
    cnt_t    fill_count;
    cnt_t    free_space;
    logic    is_empty;
  } fifo_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  rfo_req_if req_if ();
  rfo_rsp_if rsp_if ();

  ring_fifo_with_overwrite_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if.sink),
    .rsp       (rsp_if.source)
  );

  // Our own copy of the FIFO: element memory, pointers, fill count and the overwrite enable.
  elem_t element_mem [DEPTH];
  ptr_t  head_ptr;
  ptr_t  tail_ptr;
  cnt_t  held_count;
  logic  overwrite_en;

  // Results predicted for accepted requests, oldest first.
  fifo_result_t expected_results [$];

  int error_count;
  int cycle_count;

  // Upper bounds of the random gaps; a bound of zero gives a stretch with no idling.
  int req_max_gap;
  int rsp_max_stall;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic ptr_t next_slot(ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? ptr_t'(0) : ptr_t'(p + 1'b1);
  endfunction

  // Applies one request to the FIFO copy and returns the result the block must give for it.
  // All levels are taken after the request has been carried out.
  function automatic fifo_result_t predict_fifo_op(logic [1:0] op, elem_t data);
    fifo_result_t r;
    r.status    = ST_OK;
    r.read_data = '0;
    case (op)
      OP_WRITE: begin
        if (held_count == cnt_t'(DEPTH)) begin
          if (overwrite_en) begin
            // Full with overwrite: the oldest element is dropped to make room.
            head_ptr   = next_slot(head_ptr);
            held_count = held_count - 1'b1;
            r.status   = ST_OVERFLOW;
          end else begin
            r.status = ST_FULL;
          end
        end
        if (r.status != ST_FULL) begin
          element_mem[tail_ptr] = data;
          tail_ptr   = next_slot(tail_ptr);
          held_count = held_count + 1'b1;
        end
      end
      OP_READ: begin
        if (held_count == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_data = element_mem[head_ptr];
          head_ptr    = next_slot(head_ptr);
          held_count  = held_count - 1'b1;
        end
      end
      OP_CLEAR: begin
        // The memory keeps its contents; only the read side catches up with the write side.
        head_ptr   = tail_ptr;
        held_count = '0;
      end
      default: begin
      end
    endcase
    r.fill_count = held_count;
    r.free_space = cnt_t'(DEPTH) - held_count;
    r.is_empty   = (held_count == '0);
    return r;
  endfunction

  // Sends one request after a random gap and records its expected result once accepted.
  // Valid is left high after acceptance, so a following request with no gap keeps it high
  // without a second assignment in the same time step.
  task automatic send_request(logic [1:0] op, elem_t data);
    int gap;
    gap = $urandom_range(0, req_max_gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.write_data <= data;
    do @(posedge clk); while (!req_if.ready);
    expected_results.push_back(predict_fifo_op(op, data));
  endtask

  // Stops sending and waits until every expected result has come, then a little longer.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes allow_overwrite; the block is idle by then, so the copy changes at the same edge.
  task automatic set_overwrite(logic value);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    overwrite_en = value;
    cfg_we <= 1'b0;
  endtask

  // Mostly random data, with the all-zero and all-one extremes now and then.
  function automatic elem_t draw_data();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return elem_t'($urandom());
  endfunction

  // Draws an operation; write_pct steers the FIFO toward full or toward empty.
  // Clears and no-ops stay rare so that the FIFO still reaches both ends often.
  function automatic logic [1:0] draw_op(int write_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return OP_NOP;
    if (pick < 6) return OP_CLEAR;
    if ($urandom_range(0, 99) < write_pct) return OP_WRITE;
    return OP_READ;
  endfunction

  // A read and a no-op on the FIFO as it comes out of reset.
  task automatic test_empty_after_reset();
    set_overwrite(1'b0);
    send_request(OP_READ, '1);
    send_request(OP_NOP, '1);
  endtask

  // Fills all sixteen slots, with the data extremes first, then tries one write too many.
  task automatic test_write_refused_when_full();
    send_request(OP_WRITE, '0);
    send_request(OP_WRITE, '1);
    repeat (DEPTH - 2) send_request(OP_WRITE, elem_t'($urandom()));
    send_request(OP_WRITE, elem_t'($urandom()));
  endtask

  // With overwrite on, a write to the full FIFO drops the oldest element. Then a read, a
  // no-op with elements held, a clear, and a read of the cleared FIFO.
  task automatic test_overwrite_oldest();
    set_overwrite(1'b1);
    send_request(OP_WRITE, elem_t'($urandom()));
    send_request(OP_READ, '0);
    send_request(OP_NOP, '0);
    send_request(OP_CLEAR, '1);
    send_request(OP_READ, '0);
  endtask

  // Random phases under alternating register settings. Each phase runs in segments with
  // their own bias and idling; in the middle of each phase the sender holds off until
  // every result has come back.
  task automatic test_random_traffic();
    int write_pct;
    for (int phase = 0; phase < 5; phase++) begin
      set_overwrite(phase[0] ? 1'b0 : 1'b1);
      for (int seg = 0; seg < 10; seg++) begin
        case ($urandom_range(0, 2))
          0: write_pct = 80;
          1: write_pct = 50;
          default: write_pct = 20;
        endcase
        req_max_gap   = ($urandom_range(0, 2) == 0) ? 0 : 4;
        rsp_max_stall = ($urandom_range(0, 2) == 0) ? 0 : 4;
        if (seg == 5) wait_for_results();
        repeat (25) send_request(draw_op(write_pct), draw_data());
      end
    end
  endtask

  // Receiver: ready may drop for a random number of cycles before each result.
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, rsp_max_stall);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      error_count++;
    end
  endtask

  // Checker: each result taken from the block is compared with the oldest expectation.
  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request waiting: status %0d", rsp_if.status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, rsp_if.status);
        check_field("read_data", want.read_data, rsp_if.read_data);
        check_field("fill_count", want.fill_count, rsp_if.fill_count);
        check_field("free_space", want.free_space, rsp_if.free_space);
        check_field("is_empty", want.is_empty, rsp_if.is_empty);
      end
    end
  end

  // Watchdog: a run that never drains ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    error_count       = 0;
    req_max_gap       = 4;
    rsp_max_stall     = 4;
    head_ptr          = '0;
    tail_ptr          = '0;
    held_count        = '0;
    overwrite_en      = 1'b0;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.operation  <= OP_WRITE;
    req_if.write_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_after_reset();
    test_write_refused_when_full();
    test_overwrite_oldest();
    test_random_traffic();
    wait_for_results();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
